// ----- design/vrc4_pkg.sv -----
// shared types and constants for the vrc4 bank mapper with scanline irq
package vrc4_pkg;

   localparam int unsigned CHR_WINDOWS = 8;
   localparam int unsigned CHR_IDX_W = $clog2(CHR_WINDOWS);

   localparam logic [2:0] ACT_CPU_READ  = 3'd0;
   localparam logic [2:0] ACT_CPU_WRITE = 3'd1;
   localparam logic [2:0] ACT_PPU_READ  = 3'd2;
   localparam logic [2:0] ACT_PPU_WRITE = 3'd3;
   localparam logic [2:0] ACT_TICK      = 3'd4;
   localparam logic [2:0] ACT_IRQ_CLEAR = 3'd5;

   localparam logic CSR_PRG_ROM_BANKS = 1'b0;
   localparam logic CSR_CHR_ROM_BANKS = 1'b1;

   localparam logic [3:0] REG_PRG0  = 4'h8;
   localparam logic [3:0] REG_CTRL  = 4'h9;
   localparam logic [3:0] REG_PRG1  = 4'hA;
   localparam logic [3:0] REG_CHR_B = 4'hB;
   localparam logic [3:0] REG_CHR_C = 4'hC;
   localparam logic [3:0] REG_CHR_D = 4'hD;
   localparam logic [3:0] REG_CHR_E = 4'hE;
   localparam logic [3:0] REG_IRQ   = 4'hF;

   localparam logic [1:0] SEL_0 = 2'd0;
   localparam logic [1:0] SEL_1 = 2'd1;
   localparam logic [1:0] SEL_2 = 2'd2;
   localparam logic [1:0] SEL_3 = 2'd3;

   localparam logic [9:0] PRESCALE_RELOAD = 10'd342;
   localparam logic [9:0] PRESCALE_STEP   = 10'd3;
   localparam logic [9:0] PRESCALE_WRAP   = 10'd339;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic        mapped;
      logic [21:0] mapped_address;
      logic        irq_line;
      logic [2:0]  mirror_mode;
   } rsp_type;

endpackage

// ----- design/vrc4_bank_mapper_irq.sv -----
// vrc4 bank mapper: register decode, prg/chr window mapping and irq counter
// a beat accepted into the input register is processed into the result register once
// the result register is empty or being taken, and its result is shown from then on
// throughput: one beat per clock; the input register and the result register each
// advance whenever the result register is empty or being taken
// reset (synchronous, active high) empties both stages and loads the bank and irq
// registers with their power-on values; csr registers reset to 16 and 0
module vrc4_bank_mapper_irq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vrc4_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vrc4_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata
);

   logic                 in_valid_ff;
   vrc4_pkg::req_type    in_data_ff;
   logic                 out_valid_ff;
   vrc4_pkg::rsp_type    out_data_ff;
   vrc4_pkg::rsp_type    out_data_in;

   logic [7:0] prg_rom_banks_ff;
   logic [7:0] chr_rom_banks_ff;

   logic [4:0] prg_select_ff [2];
   logic [4:0] prg_select_in [2];
   logic       prg_swap_ff, prg_swap_in;
   logic [8:0] chr_select_ff [vrc4_pkg::CHR_WINDOWS];
   logic [8:0] chr_select_in [vrc4_pkg::CHR_WINDOWS];
   logic [2:0] mirror_state_ff, mirror_state_in;
   logic [7:0] irq_latch_ff, irq_latch_in;
   logic [7:0] irq_count_ff, irq_count_in;
   logic [9:0] prescale_count_ff, prescale_count_in;
   logic       irq_enabled_ff, irq_enabled_in;
   logic       irq_after_ack_ff, irq_after_ack_in;
   logic       irq_pending_ff, irq_pending_in;

   logic       advance;
   logic       proc;

   logic [2:0]  act;
   logic [15:0] addr;
   logic [7:0]  wd;
   logic [1:0]  sel;
   logic [3:0]  top;
   logic [2:0]  chr_base;
   logic [vrc4_pkg::CHR_IDX_W-1:0] chr_wr_idx;
   logic [vrc4_pkg::CHR_IDX_W-1:0] chr_rd_idx;
   logic [8:0]  last2_bank;
   logic [8:0]  last1_bank;
   logic [8:0]  prg_bank;
   logic [8:0]  chr_bank;

   assign advance   = !out_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign act  = in_data_ff.action;
   assign addr = in_data_ff.address;
   assign wd   = in_data_ff.write_data;
   // register select comes from either address line pair
   assign sel  = {addr[2] | addr[7], addr[1] | addr[6]};
   assign top  = addr[15:12];
   // B..E map to window pairs 0,2,4,6
   assign chr_base   = top[2:0] + 3'd5;
   assign chr_wr_idx = {chr_base[1:0], sel[1]};
   assign chr_rd_idx = addr[12:10];

   // fixed banks wrap at 9 bits, matching the 22-bit offset
   assign last1_bank = {prg_rom_banks_ff, 1'b0} - 9'd1;
   assign last2_bank = {prg_rom_banks_ff, 1'b0} - 9'd2;

   always_comb begin
      case (addr[14:13])
         2'd0:    prg_bank = prg_swap_ff ? last2_bank : {4'd0, prg_select_ff[0]};
         2'd1:    prg_bank = {4'd0, prg_select_ff[1]};
         2'd2:    prg_bank = prg_swap_ff ? {4'd0, prg_select_ff[0]} : last2_bank;
         default: prg_bank = last1_bank;
      endcase
   end

   assign chr_bank = chr_select_ff[chr_rd_idx];

   // state update for the beat in the input register
   always_comb begin
      prg_select_in     = prg_select_ff;
      prg_swap_in       = prg_swap_ff;
      chr_select_in     = chr_select_ff;
      mirror_state_in   = mirror_state_ff;
      irq_latch_in      = irq_latch_ff;
      irq_count_in      = irq_count_ff;
      prescale_count_in = prescale_count_ff;
      irq_enabled_in    = irq_enabled_ff;
      irq_after_ack_in  = irq_after_ack_ff;
      irq_pending_in    = irq_pending_ff;

      case (act)
         vrc4_pkg::ACT_CPU_WRITE: begin
            if (addr[15]) begin
               case (top)
                  vrc4_pkg::REG_PRG0: prg_select_in[0] = wd[4:0];
                  vrc4_pkg::REG_PRG1: prg_select_in[1] = wd[4:0];
                  vrc4_pkg::REG_CTRL: begin
                     if (sel == vrc4_pkg::SEL_0) begin
                        prg_swap_in = wd[1];
                     end else if (sel == vrc4_pkg::SEL_1) begin
                        mirror_state_in = 3'd1 + {1'b0, wd[1:0]};
                     end
                  end
                  vrc4_pkg::REG_CHR_B, vrc4_pkg::REG_CHR_C,
                  vrc4_pkg::REG_CHR_D, vrc4_pkg::REG_CHR_E: begin
                     if (sel[0]) begin
                        chr_select_in[chr_wr_idx] = {wd[4:0], chr_select_ff[chr_wr_idx][3:0]};
                     end else begin
                        chr_select_in[chr_wr_idx] = {chr_select_ff[chr_wr_idx][8:4], wd[3:0]};
                     end
                  end
                  vrc4_pkg::REG_IRQ: begin
                     case (sel)
                        vrc4_pkg::SEL_0: irq_latch_in = {irq_latch_ff[7:4], wd[3:0]};
                        vrc4_pkg::SEL_1: irq_latch_in = {wd[3:0], irq_latch_ff[3:0]};
                        vrc4_pkg::SEL_2: begin
                           irq_after_ack_in  = wd[0];
                           irq_enabled_in    = wd[1];
                           if (wd[1]) begin
                              irq_count_in = irq_latch_ff;
                           end
                           prescale_count_in = vrc4_pkg::PRESCALE_RELOAD;
                           irq_pending_in    = 1'b0;
                        end
                        default: begin
                           irq_pending_in = 1'b0;
                           irq_enabled_in = irq_after_ack_ff;
                        end
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         vrc4_pkg::ACT_TICK: begin
            if (irq_enabled_ff) begin
               // prescaler stays in 1..342; underflow wraps by adding 342 - 3
               if (prescale_count_ff <= vrc4_pkg::PRESCALE_STEP) begin
                  prescale_count_in = prescale_count_ff + vrc4_pkg::PRESCALE_WRAP;
                  if (irq_count_ff == 8'hFF) begin
                     irq_count_in   = irq_latch_ff;
                     irq_pending_in = 1'b1;
                  end else begin
                     irq_count_in = irq_count_ff + 8'd1;
                  end
               end else begin
                  prescale_count_in = prescale_count_ff - vrc4_pkg::PRESCALE_STEP;
               end
            end
         end
         vrc4_pkg::ACT_IRQ_CLEAR: irq_pending_in = 1'b0;
         default: ;
      endcase
   end

   // result for the beat in the input register
   always_comb begin
      out_data_in.mapped         = 1'b0;
      out_data_in.mapped_address = 22'd0;
      out_data_in.irq_line       = irq_pending_in;
      out_data_in.mirror_mode    = mirror_state_in;
      case (act)
         vrc4_pkg::ACT_CPU_READ: begin
            if (addr[15]) begin
               out_data_in.mapped         = 1'b1;
               out_data_in.mapped_address = {prg_bank, addr[12:0]};
            end
         end
         vrc4_pkg::ACT_PPU_READ: begin
            if (addr[15:13] == 3'd0) begin
               out_data_in.mapped         = 1'b1;
               out_data_in.mapped_address = {3'd0, chr_bank, addr[9:0]};
            end
         end
         vrc4_pkg::ACT_PPU_WRITE: begin
            if (addr[15:13] == 3'd0 && chr_rom_banks_ff == 8'd0) begin
               out_data_in.mapped         = 1'b1;
               out_data_in.mapped_address = {9'd0, addr[12:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         prg_rom_banks_ff  <= 8'd16;
         chr_rom_banks_ff  <= 8'd0;
         prg_select_ff[0]  <= 5'd0;
         prg_select_ff[1]  <= 5'd1;
         prg_swap_ff       <= 1'b0;
         for (int i = 0; i < vrc4_pkg::CHR_WINDOWS; i++) begin
            chr_select_ff[i] <= 9'd0;
         end
         mirror_state_ff   <= 3'd0;
         irq_latch_ff      <= 8'd0;
         irq_count_ff      <= 8'd0;
         prescale_count_ff <= vrc4_pkg::PRESCALE_RELOAD;
         irq_enabled_ff    <= 1'b0;
         irq_after_ack_ff  <= 1'b0;
         irq_pending_ff    <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_we) begin
            if (csr_index == vrc4_pkg::CSR_PRG_ROM_BANKS) begin
               prg_rom_banks_ff <= csr_wdata;
            end else begin
               chr_rom_banks_ff <= csr_wdata;
            end
         end
         if (proc) begin
            prg_select_ff     <= prg_select_in;
            prg_swap_ff       <= prg_swap_in;
            chr_select_ff     <= chr_select_in;
            mirror_state_ff   <= mirror_state_in;
            irq_latch_ff      <= irq_latch_in;
            irq_count_ff      <= irq_count_in;
            prescale_count_ff <= prescale_count_in;
            irq_enabled_ff    <= irq_enabled_in;
            irq_after_ack_ff  <= irq_after_ack_in;
            irq_pending_ff    <= irq_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (proc) begin
         out_data_ff <= out_data_in;
      end
   end

   a_prescale_range: assert property (@(posedge clock) disable iff (reset)
      prescale_count_ff >= 10'd1 && prescale_count_ff <= vrc4_pkg::PRESCALE_RELOAD)
      else $error("prescaler out of range");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc |=> in_valid_ff && $stable(in_data_ff))
      else $error("input beat lost while stalled");

   a_irq_clear: assert property (@(posedge clock) disable iff (reset)
      proc && act == vrc4_pkg::ACT_IRQ_CLEAR |=> !irq_pending_ff && !rsp_data.irq_line)
      else $error("irq clear did not drop pending");

   a_tick_disabled: assert property (@(posedge clock) disable iff (reset)
      proc && act == vrc4_pkg::ACT_TICK && !irq_enabled_ff
      |=> $stable(prescale_count_ff) && $stable(irq_count_ff))
      else $error("counter moved while disabled");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.mapped |-> rsp_data.mapped_address == 22'd0)
      else $error("unmapped beat carries an address");

endmodule
